### hw/rtl/iomp_pkg.sv
// ============================================================================
// iomp_pkg
// Shared types, codes and constants for the order message parser: message
// type bytes, minimum payload lengths, field byte windows and the word that
// travels from the framing front end to the field extraction back end.
// ============================================================================
`default_nettype none

package iomp_pkg;

  // Message type bytes and the side indicator.
  localparam logic [7:0] TYPE_ADD   = 8'h41;  // 'A'
  localparam logic [7:0] TYPE_DEL   = 8'h44;  // 'D'
  localparam logic [7:0] TYPE_EXEC  = 8'h45;  // 'E'
  localparam logic [7:0] TYPE_TRADE = 8'h50;  // 'P'
  localparam logic [7:0] SIDE_BUY   = 8'h42;  // 'B'

  // Minimum payload lengths for a record.
  localparam logic [15:0] MIN_LEN_ADD   = 16'd36;
  localparam logic [15:0] MIN_LEN_DEL   = 16'd19;
  localparam logic [15:0] MIN_LEN_EXEC  = 16'd31;
  localparam logic [15:0] MIN_LEN_TRADE = 16'd44;

  // Byte positions are carried saturated; the top code lies past every field.
  localparam int          POS_W   = 6;
  localparam logic [POS_W-1:0] POS_SAT = '1;

  // Field byte windows, inclusive.
  localparam logic [POS_W-1:0] POS_TIME_LO   = 6'd5;
  localparam logic [POS_W-1:0] POS_TIME_HI   = 6'd10;
  localparam logic [POS_W-1:0] POS_REF_LO    = 6'd11;
  localparam logic [POS_W-1:0] POS_REF_HI    = 6'd18;
  localparam logic [POS_W-1:0] POS_SIDE      = 6'd19;
  localparam logic [POS_W-1:0] POS_SHR_E_LO  = 6'd19;
  localparam logic [POS_W-1:0] POS_SHR_E_HI  = 6'd22;
  localparam logic [POS_W-1:0] POS_SHR_LO    = 6'd20;
  localparam logic [POS_W-1:0] POS_SHR_HI    = 6'd23;
  localparam logic [POS_W-1:0] POS_PRICE_LO  = 6'd32;
  localparam logic [POS_W-1:0] POS_PRICE_HI  = 6'd35;

  // Record kind codes.
  localparam logic [1:0] KIND_LIMIT  = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_MARKET = 2'd2;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Message class, settled by the type byte and the payload length.
  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_ADD   = 3'd1,
    CLS_DEL   = 3'd2,
    CLS_EXEC  = 3'd3,
    CLS_TRADE = 3'd4
  } msg_class_t;

  // One payload byte, tagged by the front end.
  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    msg_class_t       cls;
    logic             last;
  } token_t;

  function automatic msg_class_t classify(input logic [7:0] type_byte,
                                          input logic [15:0] len);
    msg_class_t cls;
    cls = CLS_NONE;
    if (type_byte == TYPE_ADD && len >= MIN_LEN_ADD) begin
      cls = CLS_ADD;
    end else if (type_byte == TYPE_DEL && len >= MIN_LEN_DEL) begin
      cls = CLS_DEL;
    end else if (type_byte == TYPE_EXEC && len >= MIN_LEN_EXEC) begin
      cls = CLS_EXEC;
    end else if (type_byte == TYPE_TRADE && len >= MIN_LEN_TRADE) begin
      cls = CLS_TRADE;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/iomp_front.sv
// ============================================================================
// iomp_front
// Framing front end: follows the length header and payload of each message,
// classifies the message on its type byte and hands every payload byte on as
// a tagged word.
// ============================================================================
`default_nettype none

module iomp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_fire,
  input  wire logic [7:0]      data_byte,
  input  wire logic            end_of_stream,
  output logic                 push,
  output iomp_pkg::token_t     push_token
);

  typedef enum logic [2:0] {
    PH_LEN_HI  = 3'b001,
    PH_LEN_LO  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  phase_t                phase, phase_next;
  logic [15:0]           payload_length, payload_length_next;
  logic [15:0]           byte_position, byte_position_next;
  iomp_pkg::msg_class_t  msg_class, msg_class_next;

  logic [16:0]           pos_inc;
  logic                  tok_valid;
  iomp_pkg::msg_class_t  cls_cur;
  logic                  is_last;

  assign pos_inc = {1'b0, byte_position} + 17'd1;
  assign is_last = pos_inc >= {1'b0, payload_length};
  // The type byte classifies its own word; later bytes use the stored class.
  assign cls_cur = (byte_position == 16'd0) ?
                   iomp_pkg::classify(data_byte, payload_length) : msg_class;

  always_comb begin
    phase_next          = phase;
    payload_length_next = payload_length;
    byte_position_next  = byte_position;
    msg_class_next      = msg_class;
    tok_valid           = 1'b0;
    unique case (phase)
      PH_LEN_HI: begin
        payload_length_next = {data_byte, 8'h00};
        phase_next          = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_length_next = {payload_length[15:8], data_byte};
        byte_position_next  = 16'd0;
        phase_next          = (payload_length_next == 16'd0) ? PH_LEN_HI : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        tok_valid      = 1'b1;
        msg_class_next = cls_cur;
        if (is_last) begin
          phase_next         = PH_LEN_HI;
          byte_position_next = 16'd0;
        end else begin
          byte_position_next = pos_inc[15:0];
        end
      end
      default: begin
        phase_next = PH_LEN_HI;
      end
    endcase
    if (end_of_stream) begin
      phase_next          = PH_LEN_HI;
      payload_length_next = 16'd0;
      byte_position_next  = 16'd0;
    end
  end

  assign push            = in_fire && tok_valid;
  assign push_token.data = data_byte;
  assign push_token.pos  = (byte_position > 16'(iomp_pkg::POS_SAT)) ?
                           iomp_pkg::POS_SAT : byte_position[iomp_pkg::POS_W-1:0];
  assign push_token.cls  = cls_cur;
  assign push_token.last = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEN_HI;
      payload_length <= 16'd0;
      byte_position  <= 16'd0;
      msg_class      <= iomp_pkg::CLS_NONE;
    end else if (in_fire) begin
      phase          <= phase_next;
      payload_length <= payload_length_next;
      byte_position  <= byte_position_next;
      msg_class      <= msg_class_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/iomp_queue.sv
// ============================================================================
// iomp_queue
// Short first-in first-out queue of tagged payload words between the front
// and back ends, built from flip-flops.
// ============================================================================
`default_nettype none

module iomp_queue #(
  parameter int DEPTH = iomp_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire iomp_pkg::token_t  push_token,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output iomp_pkg::token_t       head_token
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  iomp_pkg::token_t  slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_token = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/iomp_back.sv
// ============================================================================
// iomp_back
// Field extraction back end: shifts payload bytes into the field
// accumulators and loads the output register with an order record on the
// final byte of a qualifying message.
// ============================================================================
`default_nettype none

module iomp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire iomp_pkg::token_t  head_token,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             order_kind,
  output logic [47:0]            stamp_ns,
  output logic [63:0]            order_ref,
  output logic                   sell_side,
  output logic [31:0]            share_count,
  output logic [31:0]            price_fixed
);

  logic [47:0] time_accum, time_accum_next;
  logic [63:0] ref_accum, ref_accum_next;
  logic        side_flag, side_flag_next;
  logic [31:0] shares_accum, shares_accum_next;
  logic [31:0] price_accum, price_accum_next;

  logic [iomp_pkg::POS_W-1:0] pos;
  logic [7:0]                 b;
  logic                       emit;
  logic                       in_shr;

  assign pos = head_token.pos;
  assign b   = head_token.data;

  always_comb begin
    time_accum_next   = time_accum;
    ref_accum_next    = ref_accum;
    side_flag_next    = side_flag;
    shares_accum_next = shares_accum;
    price_accum_next  = price_accum;
    if (pos >= iomp_pkg::POS_TIME_LO && pos <= iomp_pkg::POS_TIME_HI) begin
      time_accum_next = {time_accum[39:0], b};
    end
    if (pos >= iomp_pkg::POS_REF_LO && pos <= iomp_pkg::POS_REF_HI) begin
      ref_accum_next = {ref_accum[55:0], b};
    end
    if (pos == iomp_pkg::POS_SIDE) begin
      side_flag_next = (b != iomp_pkg::SIDE_BUY);
    end
    // Executed messages carry shares one byte earlier.
    if (head_token.cls == iomp_pkg::CLS_EXEC) begin
      in_shr = pos >= iomp_pkg::POS_SHR_E_LO && pos <= iomp_pkg::POS_SHR_E_HI;
    end else begin
      in_shr = pos >= iomp_pkg::POS_SHR_LO && pos <= iomp_pkg::POS_SHR_HI;
    end
    if (in_shr) begin
      shares_accum_next = {shares_accum[23:0], b};
    end
    if (pos >= iomp_pkg::POS_PRICE_LO && pos <= iomp_pkg::POS_PRICE_HI) begin
      price_accum_next = {price_accum[23:0], b};
    end
  end

  assign emit = head_token.last && (head_token.cls != iomp_pkg::CLS_NONE);
  assign pop  = head_valid && (!emit || !out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (pop) begin
      time_accum   <= time_accum_next;
      ref_accum    <= ref_accum_next;
      side_flag    <= side_flag_next;
      shares_accum <= shares_accum_next;
      price_accum  <= price_accum_next;
    end
    if (pop && emit) begin
      stamp_ns     <= time_accum_next;
      order_ref    <= ref_accum_next;
      sell_side    <= 1'b0;
      share_count  <= shares_accum_next;
      price_fixed  <= 32'd0;
      case (head_token.cls)
        iomp_pkg::CLS_ADD: begin
          order_kind  <= iomp_pkg::KIND_LIMIT;
          sell_side   <= side_flag_next;
          price_fixed <= price_accum_next;
        end
        iomp_pkg::CLS_DEL: begin
          order_kind  <= iomp_pkg::KIND_CANCEL;
          share_count <= 32'd0;
        end
        iomp_pkg::CLS_TRADE: begin
          order_kind  <= iomp_pkg::KIND_MARKET;
          sell_side   <= side_flag_next;
          price_fixed <= price_accum_next;
        end
        default: begin
          order_kind <= iomp_pkg::KIND_MARKET;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/itch_order_message_parser.sv
// ============================================================================
// itch_order_message_parser
// Order message parser for a length-framed market data byte stream.
// ============================================================================
// The input channel (in_valid, in_stall, data_byte, end_of_stream) takes one
// word per cycle: a byte of the stream, each message being a two-byte
// big-endian payload length followed by the payload. A word is taken at a
// rising edge with in_valid high and in_stall low. end_of_stream marks the
// last byte of the stream; a message cut short by it gives no record.
// The output channel (out_valid, out_stall, record fields) presents one
// order record for each add, delete, executed or trade message that is long
// enough. The final payload byte is written into the queue, and the back end
// then loads its record into the output register.
// Throughput is one byte per cycle: the front end tracks framing and
// classifies each message on its type byte, and a short word queue feeds the
// back end, which shifts bytes into the field accumulators and fills the
// output register. When the receiver stalls, the back end holds the record
// and keeps absorbing bytes that produce no record; once the queue fills,
// in_stall rises. Reset clears the framing state, the queue and out_valid.
// ============================================================================
`default_nettype none

module itch_order_message_parser #(
  parameter int QUEUE_DEPTH = iomp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_stream,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       order_kind,
  output logic [47:0]      stamp_ns,
  output logic [63:0]      order_ref,
  output logic             sell_side,
  output logic [31:0]      share_count,
  output logic [31:0]      price_fixed
);

  logic              in_fire;
  logic              push;
  iomp_pkg::token_t  push_token;
  logic              queue_full;
  logic              pop;
  logic              head_valid;
  iomp_pkg::token_t  head_token;

  // The input stalls only while the queue is full.
  assign in_stall = queue_full;
  assign in_fire  = in_valid && !queue_full;

  iomp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .push          (push),
    .push_token    (push_token)
  );

  iomp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_token (head_token)
  );

  iomp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_token   (head_token),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .order_kind   (order_kind),
    .stamp_ns     (stamp_ns),
    .order_ref    (order_ref),
    .sell_side    (sell_side),
    .share_count  (share_count),
    .price_fixed  (price_fixed)
  );

endmodule

`default_nettype wire

### tb/sv/itch_order_message_parser_tb.sv
// ============================================================================
// itch_order_message_parser_tb
// Self-checking testbench for the length-framed order message parser.
// ============================================================================
// The stimulus is a byte stream of framed messages. Each word is one byte,
// with the end_of_stream flag. A shadow parser in this file follows every
// word that the block takes. It keeps the framing state and the field
// accumulators, and it queues the order record that each complete add,
// delete, executed or trade message should give. A checker pops one
// expected record for each record that the block hands over, and compares
// it field by field.
// Directed tests cover field extremes, every record kind with its length
// boundary, zero-length frames, streams that end in mid message, a stream
// that ends on a final byte and extra payload past the saturated position.
// A long receiver hold-off then fills the block. A random stream follows,
// with idle bursts on both sides, and the run ends with a quiet tail.
// ============================================================================

module itch_order_message_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] SIDE_SELL      = 8'h53;  // 'S'
  localparam logic [7:0] TYPE_OTHER     = 8'h61;  // 'a', not an order type
  localparam int         NO_EOS         = -1;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         RANDOM_BYTES   = 150;
  localparam int         DRAIN_LIMIT    = 2000;
  localparam int         TAIL_CYCLES    = 8;

  // Minimum lengths and field windows as plain integers.
  localparam int ADD_LEN    = int'(iomp_pkg::MIN_LEN_ADD);
  localparam int DEL_LEN    = int'(iomp_pkg::MIN_LEN_DEL);
  localparam int EXEC_LEN   = int'(iomp_pkg::MIN_LEN_EXEC);
  localparam int TRADE_LEN  = int'(iomp_pkg::MIN_LEN_TRADE);
  localparam int TIME_LO    = int'(iomp_pkg::POS_TIME_LO);
  localparam int TIME_HI    = int'(iomp_pkg::POS_TIME_HI);
  localparam int REF_LO     = int'(iomp_pkg::POS_REF_LO);
  localparam int REF_HI     = int'(iomp_pkg::POS_REF_HI);
  localparam int SIDE_POS   = int'(iomp_pkg::POS_SIDE);
  localparam int SHR_E_LO   = int'(iomp_pkg::POS_SHR_E_LO);
  localparam int SHR_E_HI   = int'(iomp_pkg::POS_SHR_E_HI);
  localparam int SHR_LO     = int'(iomp_pkg::POS_SHR_LO);
  localparam int SHR_HI     = int'(iomp_pkg::POS_SHR_HI);
  localparam int PRICE_LO   = int'(iomp_pkg::POS_PRICE_LO);
  localparam int PRICE_HI   = int'(iomp_pkg::POS_PRICE_HI);

  // Framing phase of the shadow parser.
  typedef enum logic [2:0] {
    WAIT_LEN_HI = 3'b001,
    WAIT_LEN_LO = 3'b010,
    IN_PAYLOAD  = 3'b100
  } frame_phase_t;

  // How the payload bytes that carry no type or side are filled.
  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  typedef struct {
    logic [1:0]  kind;
    logic [47:0] stamp;
    logic [63:0] oref;
    logic        ask;
    logic [31:0] shares;
    logic [31:0] price;
  } order_rec_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte     = 8'h00;
  logic        end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [1:0]  order_kind;
  logic [47:0] stamp_ns;
  logic [63:0] order_ref;
  logic        sell_side;
  logic [31:0] share_count;
  logic [31:0] price_fixed;

  // Knobs shared by the test tasks and the receiver.
  bit tx_idle_on   = 1'b0;
  bit rx_stall_on  = 1'b0;
  bit hold_request = 1'b0;

  // Shadow parser state.
  frame_phase_t shadow_phase = WAIT_LEN_HI;
  logic [15:0]  shadow_len   = '0;
  int           shadow_pos   = 0;
  logic [7:0]   shadow_type  = '0;
  logic [47:0]  acc_stamp    = '0;
  logic [63:0]  acc_ref      = '0;
  logic         acc_ask      = 1'b0;
  logic [31:0]  acc_shares   = '0;
  logic [31:0]  acc_price    = '0;

  order_rec_t expected_orders[$];

  int bytes_accepted     = 0;
  int messages_sent      = 0;
  int messages_cut       = 0;
  int records_predicted  = 0;
  int records_checked    = 0;
  int input_stall_cycles = 0;
  int mismatch_count     = 0;

  itch_order_message_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .order_kind    (order_kind),
    .stamp_ns      (stamp_ns),
    .order_ref     (order_ref),
    .sell_side     (sell_side),
    .share_count   (share_count),
    .price_fixed   (price_fixed)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow parser
  // --------------------------------------------------------------------------

  function automatic void clear_fields();
    shadow_type = '0;
    acc_stamp   = '0;
    acc_ref     = '0;
    acc_ask     = 1'b0;
    acc_shares  = '0;
    acc_price   = '0;
  endfunction

  // Follows one accepted word and queues the record that it completes, if any.
  function automatic void track_stream_byte(input logic [7:0] b, input logic eos);
    order_rec_t rec;
    bit         gives_record;
    rec          = '{default: '0};
    gives_record = 1'b1;
    case (shadow_phase)
      WAIT_LEN_HI: begin
        shadow_len   = {b, 8'h00};
        shadow_phase = WAIT_LEN_LO;
      end
      WAIT_LEN_LO: begin
        shadow_len[7:0] = b;
        shadow_pos      = 0;
        clear_fields();
        // A zero-length frame has no payload at all.
        shadow_phase = (shadow_len == 16'd0) ? WAIT_LEN_HI : IN_PAYLOAD;
      end
      default: begin
        if (shadow_pos == 0) begin
          shadow_type = b;
        end else begin
          if (shadow_pos >= TIME_LO && shadow_pos <= TIME_HI) begin
            acc_stamp = {acc_stamp[39:0], b};
          end
          if (shadow_pos >= REF_LO && shadow_pos <= REF_HI) begin
            acc_ref = {acc_ref[55:0], b};
          end
          if (shadow_pos == SIDE_POS) begin
            acc_ask = (b != iomp_pkg::SIDE_BUY);
          end
          // Executed messages carry their share count one byte earlier.
          if (shadow_type == iomp_pkg::TYPE_EXEC) begin
            if (shadow_pos >= SHR_E_LO && shadow_pos <= SHR_E_HI) begin
              acc_shares = {acc_shares[23:0], b};
            end
          end else if (shadow_pos >= SHR_LO && shadow_pos <= SHR_HI) begin
            acc_shares = {acc_shares[23:0], b};
          end
          if (shadow_pos >= PRICE_LO && shadow_pos <= PRICE_HI) begin
            acc_price = {acc_price[23:0], b};
          end
        end
        if (shadow_pos + 1 >= int'(shadow_len)) begin
          if (shadow_type == iomp_pkg::TYPE_ADD && shadow_len >= iomp_pkg::MIN_LEN_ADD) begin
            rec.kind   = iomp_pkg::KIND_LIMIT;
            rec.ask    = acc_ask;
            rec.shares = acc_shares;
            rec.price  = acc_price;
          end else if (shadow_type == iomp_pkg::TYPE_DEL &&
                       shadow_len >= iomp_pkg::MIN_LEN_DEL) begin
            rec.kind = iomp_pkg::KIND_CANCEL;
          end else if (shadow_type == iomp_pkg::TYPE_EXEC &&
                       shadow_len >= iomp_pkg::MIN_LEN_EXEC) begin
            rec.kind   = iomp_pkg::KIND_MARKET;
            rec.shares = acc_shares;
          end else if (shadow_type == iomp_pkg::TYPE_TRADE &&
                       shadow_len >= iomp_pkg::MIN_LEN_TRADE) begin
            rec.kind   = iomp_pkg::KIND_MARKET;
            rec.ask    = acc_ask;
            rec.shares = acc_shares;
            rec.price  = acc_price;
          end else begin
            gives_record = 1'b0;
          end
          if (gives_record) begin
            rec.stamp = acc_stamp;
            rec.oref  = acc_ref;
            expected_orders.insert(expected_orders.size(), rec);
            records_predicted++;
          end
          shadow_phase = WAIT_LEN_HI;
          shadow_pos   = 0;
        end else begin
          shadow_pos++;
        end
      end
    endcase
    // End of stream drops any partial message and clears the framing state and fields.
    if (eos) begin
      shadow_phase = WAIT_LEN_HI;
      shadow_len   = '0;
      shadow_pos   = 0;
      clear_fields();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offers one word and returns at the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    bytes_accepted++;
    track_stream_byte(b, eos);
  endtask

  // Sends one framed message. Word index 0 and 1 are the length bytes; the
  // stream ends on word eos_at, which may cut the message short.
  task automatic send_message(input logic [7:0] kind_byte, input int len,
                              input logic [7:0] side_byte, input fill_t fill,
                              input int eos_at);
    logic [15:0] frame_len;
    logic [7:0]  b;
    int          idx;
    int          pos;
    frame_len = len[15:0];
    messages_sent++;
    if (eos_at >= 0 && eos_at < len + 1) begin
      messages_cut++;
    end
    for (idx = 0; idx < len + 2; idx++) begin
      pos = idx - 2;
      if (idx == 0) begin
        b = frame_len[15:8];
      end else if (idx == 1) begin
        b = frame_len[7:0];
      end else if (pos == 0) begin
        b = kind_byte;
      end else if (pos == SIDE_POS) begin
        b = side_byte;
      end else begin
        case (fill)
          FILL_ZERO: b = 8'h00;
          FILL_ONES: b = 8'hFF;
          default:   b = 8'($urandom_range(0, 255));
        endcase
      end
      send_byte(b, idx == eos_at);
      if (idx == eos_at) begin
        break;
      end
    end
  endtask

  // Mostly order messages near their length boundary, with some short or
  // foreign ones and an occasional end of stream.
  task automatic send_random_message();
    logic [7:0] kind_byte;
    logic [7:0] side_byte;
    int         min_len;
    int         len;
    int         eos_at;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      kind_byte = iomp_pkg::TYPE_ADD;
      min_len   = ADD_LEN;
    end else if (pick < 40) begin
      kind_byte = iomp_pkg::TYPE_DEL;
      min_len   = DEL_LEN;
    end else if (pick < 57) begin
      kind_byte = iomp_pkg::TYPE_EXEC;
      min_len   = EXEC_LEN;
    end else if (pick < 77) begin
      kind_byte = iomp_pkg::TYPE_TRADE;
      min_len   = TRADE_LEN;
    end else begin
      kind_byte = 8'($urandom_range(0, 255));
      min_len   = 0;
    end
    pick = $urandom_range(0, 99);
    if (min_len == 0 || pick < 8) begin
      len = $urandom_range(0, 60);
    end else if (pick < 18) begin
      len = min_len - $urandom_range(1, 4);
    end else begin
      len = min_len + $urandom_range(0, 12);
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      side_byte = iomp_pkg::SIDE_BUY;
    end else if (pick < 75) begin
      side_byte = SIDE_SELL;
    end else begin
      side_byte = 8'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      eos_at = $urandom_range(0, len + 1);
    end else if (pick < 7) begin
      eos_at = len + 1;
    end else begin
      eos_at = NO_EOS;
    end
    send_message(kind_byte, len, side_byte, FILL_RANDOM, eos_at);
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------

  // Random stall bursts, or one long counted hold-off on request.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : record_check
    order_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_orders.size() == 0) begin
        $error("order record with none expected: kind %0d ref 0x%0h",
               order_kind, order_ref);
        mismatch_count++;
      end else begin
        want = expected_orders.pop_front();
        check_field("order_kind", 64'(want.kind), 64'(order_kind));
        check_field("stamp_ns", 64'(want.stamp), 64'(stamp_ns));
        check_field("order_ref", want.oref, order_ref);
        check_field("sell_side", 64'(want.ask), 64'(sell_side));
        check_field("share_count", 64'(want.shares), 64'(share_count));
        check_field("price_fixed", 64'(want.price), 64'(price_fixed));
        records_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // All-zero and all-one fields for the record kinds, both sides.
  task automatic test_field_extremes();
    send_message(iomp_pkg::TYPE_ADD, ADD_LEN, iomp_pkg::SIDE_BUY, FILL_ZERO, NO_EOS);
    send_message(iomp_pkg::TYPE_ADD, ADD_LEN, 8'hFF, FILL_ONES, NO_EOS);
    send_message(iomp_pkg::TYPE_TRADE, TRADE_LEN, 8'hFF, FILL_ONES, NO_EOS);
    send_message(iomp_pkg::TYPE_EXEC, EXEC_LEN, 8'hFF, FILL_ONES, NO_EOS);
    send_message(iomp_pkg::TYPE_DEL, DEL_LEN, 8'hFF, FILL_ONES, NO_EOS);
  endtask

  // Each kind at its minimum length and one byte short, then foreign types.
  task automatic test_kinds_and_lengths();
    send_message(iomp_pkg::TYPE_ADD, ADD_LEN, SIDE_SELL, FILL_RANDOM, NO_EOS);
    send_message(iomp_pkg::TYPE_ADD, ADD_LEN - 1, iomp_pkg::SIDE_BUY, FILL_RANDOM, NO_EOS);
    send_message(iomp_pkg::TYPE_DEL, DEL_LEN, iomp_pkg::SIDE_BUY, FILL_RANDOM, NO_EOS);
    send_message(iomp_pkg::TYPE_DEL, DEL_LEN - 1, iomp_pkg::SIDE_BUY, FILL_RANDOM, NO_EOS);
    send_message(iomp_pkg::TYPE_EXEC, EXEC_LEN, SIDE_SELL, FILL_RANDOM, NO_EOS);
    send_message(iomp_pkg::TYPE_EXEC, EXEC_LEN - 1, iomp_pkg::SIDE_BUY, FILL_RANDOM,
                 NO_EOS);
    send_message(iomp_pkg::TYPE_TRADE, TRADE_LEN, iomp_pkg::SIDE_BUY, FILL_RANDOM, NO_EOS);
    send_message(iomp_pkg::TYPE_TRADE, TRADE_LEN - 1, SIDE_SELL, FILL_RANDOM, NO_EOS);
    send_message(SIDE_SELL, 11, iomp_pkg::SIDE_BUY, FILL_RANDOM, NO_EOS);
    send_message(TYPE_OTHER, 20, iomp_pkg::SIDE_BUY, FILL_RANDOM, NO_EOS);
  endtask

  // Zero-length frames, one of them closing the stream.
  task automatic test_zero_length();
    send_message(TYPE_OTHER, 0, iomp_pkg::SIDE_BUY, FILL_RANDOM, NO_EOS);
    send_message(iomp_pkg::TYPE_DEL, DEL_LEN, iomp_pkg::SIDE_BUY, FILL_RANDOM, NO_EOS);
    send_message(TYPE_OTHER, 0, iomp_pkg::SIDE_BUY, FILL_RANDOM, 1);
    send_message(iomp_pkg::TYPE_EXEC, EXEC_LEN, iomp_pkg::SIDE_BUY, FILL_RANDOM, NO_EOS);
  endtask

  // The stream ends on either length byte, in mid payload and one byte
  // before the end; a whole message must still parse afterwards.
  task automatic test_cut_short();
    send_message(iomp_pkg::TYPE_ADD, ADD_LEN, SIDE_SELL, FILL_RANDOM, 0);
    send_message(iomp_pkg::TYPE_ADD, ADD_LEN, SIDE_SELL, FILL_RANDOM, 1);
    send_message(iomp_pkg::TYPE_ADD, ADD_LEN, SIDE_SELL, FILL_RANDOM, 22);
    send_message(iomp_pkg::TYPE_ADD, ADD_LEN, SIDE_SELL, FILL_RANDOM, ADD_LEN);
    send_message(iomp_pkg::TYPE_ADD, ADD_LEN, SIDE_SELL, FILL_RANDOM, NO_EOS);
    send_message(iomp_pkg::TYPE_TRADE, 16'hFF00, iomp_pkg::SIDE_BUY, FILL_RANDOM, 7);
    send_message(iomp_pkg::TYPE_DEL, DEL_LEN, iomp_pkg::SIDE_BUY, FILL_RANDOM, NO_EOS);
  endtask

  // The stream ends on a final payload byte: the record still comes out.
  task automatic test_complete_at_end();
    send_message(iomp_pkg::TYPE_TRADE, TRADE_LEN, SIDE_SELL, FILL_RANDOM, TRADE_LEN + 1);
    send_message(iomp_pkg::TYPE_DEL, DEL_LEN, iomp_pkg::SIDE_BUY, FILL_RANDOM,
                 DEL_LEN + 1);
  endtask

  // Payload bytes past the last field are ignored, also past the point
  // where the block's byte position saturates.
  task automatic test_extra_payload();
    send_message(iomp_pkg::TYPE_ADD, 40, iomp_pkg::SIDE_BUY, FILL_RANDOM, NO_EOS);
    send_message(iomp_pkg::TYPE_TRADE, 48, SIDE_SELL, FILL_RANDOM, NO_EOS);
    send_message(iomp_pkg::TYPE_DEL, 24, iomp_pkg::SIDE_BUY, FILL_RANDOM, NO_EOS);
    send_message(iomp_pkg::TYPE_EXEC, 70, iomp_pkg::SIDE_BUY, FILL_RANDOM, NO_EOS);
  endtask

  // The receiver holds off while the sender keeps streaming, so that the
  // block fills up and pushes back on its input.
  task automatic test_backpressure();
    int i;
    tx_idle_on   = 1'b0;
    hold_request = 1'b1;
    for (i = 0; i < 3; i++) begin
      send_message(iomp_pkg::TYPE_ADD, ADD_LEN + i, SIDE_SELL, FILL_RANDOM, NO_EOS);
    end
  endtask

  task automatic test_random_stream();
    int start_bytes;
    start_bytes = bytes_accepted;
    while (bytes_accepted - start_bytes < RANDOM_BYTES) begin
      tx_idle_on  = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      send_random_message();
    end
  endtask

  // Back-to-back words and no receiver stalls to close the run.
  task automatic test_quiet_tail();
    int i;
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    for (i = 0; i < 3; i++) begin
      send_random_message();
    end
  endtask

  // --------------------------------------------------------------------------
  // Run
  // --------------------------------------------------------------------------

  initial begin : run
    int waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    test_field_extremes();
    test_kinds_and_lengths();
    test_zero_length();
    test_cut_short();
    test_complete_at_end();
    test_extra_payload();
    test_backpressure();
    test_random_stream();
    test_quiet_tail();

    in_valid <= 1'b0;
    waited = 0;
    while (expected_orders.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_orders.size() != 0) begin
      $error("%0d expected order records never came out", expected_orders.size());
      mismatch_count += expected_orders.size();
    end

    $display("Streamed %0d bytes in %0d messages, %0d of them ended early by the stream.",
             bytes_accepted, messages_sent, messages_cut);
    $display("Checked %0d order records; input held off for %0d cycles.",
             records_checked, input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guards against a hung handshake.
  initial begin : watchdog
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
hw/rtl/iomp_pkg.sv
hw/rtl/iomp_front.sv
hw/rtl/iomp_queue.sv
hw/rtl/iomp_back.sv
hw/rtl/itch_order_message_parser.sv
tb/sv/itch_order_message_parser_tb.sv
